FILE: hw/rtl/pixel_3x3x3_convolution_filter_assert.svh
// Assertion macros used by the convolution filter RTL
`ifndef PIXEL_3X3X3_CONVOLUTION_FILTER_ASSERT_SVH
`define PIXEL_3X3X3_CONVOLUTION_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PCONV_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, disabled during reset
`define PCONV_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: hw/rtl/pconv_pkg.sv
// Types, register indexes and kernel table of the 3x3x3 convolution filter
`default_nettype none

package pconv_pkg;

   localparam int PIX_W     = 8;
   localparam int DIV_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int WEIGHT_W  = 7;
   localparam int TAPS      = 27;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 3'd4;

   // Register reset values
   localparam logic [1:0]  KERNEL_RESET  = 2'd0;
   localparam logic [15:0] DIVISOR_RESET = 16'd84;
   localparam logic [15:0] OFFSET_RESET  = 16'd0;
   localparam logic [11:0] WIDTH_RESET   = 12'd512;
   localparam logic [15:0] HEIGHT_RESET  = 16'd512;

   // Kernels: low pass, high pass, boxcar, smear
   localparam logic signed [WEIGHT_W-1:0] KERNEL_TABLE [0:3][0:TAPS-1] = '{
      '{7'sd1, 7'sd3, 7'sd1, 7'sd3, 7'sd5, 7'sd3, 7'sd1, 7'sd3, 7'sd1,
        7'sd3, 7'sd5, 7'sd3, 7'sd5, 7'sd10, 7'sd5, 7'sd3, 7'sd5, 7'sd3,
        7'sd1, 7'sd3, 7'sd1, 7'sd3, 7'sd5, 7'sd3, 7'sd1, 7'sd3, 7'sd1},
      '{-7'sd1, -7'sd2, -7'sd1, -7'sd2, -7'sd4, -7'sd2, -7'sd1, -7'sd2, -7'sd1,
        -7'sd2, -7'sd4, -7'sd2, -7'sd4, 7'sd56, -7'sd4, -7'sd2, -7'sd4, -7'sd2,
        -7'sd1, -7'sd2, -7'sd1, -7'sd2, -7'sd4, -7'sd2, -7'sd1, -7'sd2, -7'sd1},
      '{7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1,
        7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd27, 7'sd1, 7'sd1, 7'sd1, 7'sd1,
        7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1},
      '{7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1,
        7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1, 7'sd1,
        7'sd2, 7'sd2, 7'sd2, 7'sd2, 7'sd35, 7'sd2, 7'sd2, 7'sd2, 7'sd2}
   };

   typedef struct packed {
      logic [PIX_W-1:0] prev_red;
      logic [PIX_W-1:0] prev_green;
      logic [PIX_W-1:0] prev_blue;
      logic [PIX_W-1:0] cur_red;
      logic [PIX_W-1:0] cur_green;
      logic [PIX_W-1:0] cur_blue;
      logic [PIX_W-1:0] next_red;
      logic [PIX_W-1:0] next_green;
      logic [PIX_W-1:0] next_blue;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]      out_row;
      logic [10:0]      out_col;
      logic [PIX_W-1:0] out_red;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_blue;
      logic             last_of_run;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pconv_ram.sv
// Generic RAM with one read port and one write port, registered read
`default_nettype none

module pconv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pconv_div.sv
// Restoring divider, one quotient bit per cycle, unsigned
`default_nettype none

module pconv_div #(
   parameter int DVD_W = 18
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [DVD_W-1:0]            dividend,
   input  wire logic [pconv_pkg::DIV_W-1:0] divisor,
   output logic                             done,
   output logic      [DVD_W-1:0]            quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [pconv_pkg::DIV_W:0]   rem_ff, rem_in;
   logic [DVD_W-1:0]            quo_ff, quo_in;
   logic [pconv_pkg::DIV_W:0]   rem_sh;
   logic [pconv_pkg::DIV_W:0]   dvs_ext;
   logic                        ge;

   // Shift one dividend bit in and trial-subtract
   always_comb begin
      dvs_ext = {1'b0, divisor};
      rem_sh  = {rem_ff[pconv_pkg::DIV_W-1:0], quo_ff[DVD_W-1]};
      ge      = (rem_sh >= dvs_ext);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - dvs_ext) : rem_sh;
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_3x3x3_convolution_filter.sv
// Top level of the 3x3x3 spatiotemporal convolution filter
//
// One beat in carries the pixel at the stream position from the previous, current and next
// frame; the block answers with zero to three result beats, each tagged with its row and
// column, the last one flagged by last_of_run. Items are handled one at a time. A beat that
// needs no filtering (border pixels, row 1) holds req_ready low until its result beats are
// out; a filtered beat holds it low while the 27-tap multiply-accumulate walks the window
// one tap per cycle, while the dividers are started and run until they all signal done,
// and while its result beats go out. The next beat is taken in the following idle cycle at
// the earliest, and result-side stalls hold req_ready low for longer. The two rows above the
// stream position live in one line RAM, read when the beat is taken and written back in the
// cycle after, so no entry is ever read before its previous write lands. No clearing pass is
// needed after reset. Registers may only be written while the block is idle.
`default_nettype none
`include "pixel_3x3x3_convolution_filter_assert.svh"

module pixel_3x3x3_convolution_filter #(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire pconv_pkg::req_payload_type          req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pconv_pkg::rsp_payload_type               rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [pconv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pconv_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   localparam int AW     = $clog2(MAX_LINE_WIDTH);
   localparam int WW     = $clog2(MAX_LINE_WIDTH + 1);
   localparam int PXW    = 3 * pconv_pkg::PIX_W;
   localparam int ENT_W  = 2 * PXW;
   localparam int ACC_W  = 18;
   localparam int VAL_W  = ACC_W + 2;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_MAC  = 5'b00100,
      S_DIV  = 5'b01000,
      S_EMIT = 5'b10000
   } state_type;

   // Window slots in the current frame: newest pixel of the current row, middle and newest of the row above
   localparam int WIN_CUR  = 17;
   localparam int WIN_MID1 = 13;
   localparam int WIN_MID2 = 14;

   state_type                         state_ff, state_in;
   logic [1:0]                        kern_ff, kern_in;
   logic [15:0]                       divisor_ff, divisor_in;
   logic [15:0]                       offset_ff, offset_in;
   logic [11:0]                       lw_ff, lw_in;
   logic [15:0]                       fh_ff, fh_in;
   logic [AW-1:0]                     col_ff, col_in;
   logic [15:0]                       row_ff, row_in;
   logic [AW-1:0]                     em_col_ff, em_col_in;
   logic [15:0]                       em_row_ff, em_row_in;
   logic [2:0]                        emit_mask_ff, emit_mask_in;
   logic                              need_filt_ff, need_filt_in;
   pconv_pkg::req_payload_type        req_ff, req_in;
   logic [PXW-1:0]                    win_ff [pconv_pkg::TAPS];
   logic [PXW-1:0]                    win_in [pconv_pkg::TAPS];
   logic [1:0]                        tf_ff, tf_in, tr_ff, tr_in, tc_ff, tc_in;
   logic signed [ACC_W-1:0]           acc_ff [3];
   logic signed [ACC_W-1:0]           acc_in [3];
   logic [2:0]                        neg_ff, neg_in;
   logic [PXW-1:0]                    filt_ff, filt_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pconv_pkg::rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic                              accept;
   logic                              ram_we;
   logic [3*ENT_W-1:0]                ram_rdata, ram_wdata;
   logic [WW-1:0]                     w_eff;
   logic [15:0]                       h_eff;
   logic                              last_col, last_row;
   logic [PXW-1:0]                    in_pix [3];
   logic [4:0]                        widx, kidx;
   logic signed [pconv_pkg::WEIGHT_W-1:0] weight;
   logic                              div_start;
   logic [ACC_W-1:0]                  div_mag [3];
   logic [ACC_W-1:0]                  div_quo [3];
   logic [2:0]                        div_done;
   logic [15:0]                       div_eff;
   logic                              out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_pix[0] = {req_ff.prev_blue, req_ff.prev_green, req_ff.prev_red};
   assign in_pix[1] = {req_ff.cur_blue, req_ff.cur_green, req_ff.cur_red};
   assign in_pix[2] = {req_ff.next_blue, req_ff.next_green, req_ff.next_red};

   // Effective geometry and divisor
   always_comb begin
      if (lw_ff < 12'd3) begin
         w_eff = WW'(3);
      end else if (32'(lw_ff) > MAX_LINE_WIDTH) begin
         w_eff = WW'(MAX_LINE_WIDTH);
      end else begin
         w_eff = WW'(lw_ff);
      end
      h_eff    = (fh_ff < 16'd3) ? 16'd3 : fh_ff;
      div_eff  = (divisor_ff == 16'd0) ? 16'd1 : divisor_ff;
      last_col = ((AW + 1)'(col_ff) + 1'b1) >= (AW + 1)'(w_eff);
      last_row = (17'(row_ff) + 17'd1) >= 17'(h_eff);
   end

   // Configuration writes
   always_comb begin
      kern_in    = kern_ff;
      divisor_in = divisor_ff;
      offset_in  = offset_ff;
      lw_in      = lw_ff;
      fh_in      = fh_ff;
      if (csr_we) begin
         unique case (csr_index)
            pconv_pkg::CSR_KERNEL_SELECT: kern_in    = csr_wdata[1:0];
            pconv_pkg::CSR_DIVISOR:       divisor_in = csr_wdata;
            pconv_pkg::CSR_OFFSET:        offset_in  = csr_wdata;
            pconv_pkg::CSR_LINE_WIDTH:    lw_in      = csr_wdata[11:0];
            pconv_pkg::CSR_FRAME_HEIGHT:  fh_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   // Line RAM: per frame, row above in the low half, two above in the high half
   assign ram_we = (state_ff == S_READ);
   always_comb begin
      for (int f = 0; f < 3; f++) begin
         ram_wdata[f*ENT_W +: ENT_W] = {ram_rdata[f*ENT_W +: PXW], in_pix[f]};
      end
   end

   pconv_ram #(
      .WIDTH (3 * ENT_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rdata),
      .wr_en   (ram_we),
      .wr_addr (col_ff),
      .wr_data (ram_wdata)
   );

   // Tap addressing for the multiply-accumulate
   always_comb begin
      kidx   = 5'(tf_ff) * 5'd9 + 5'(tr_ff) * 5'd3 + 5'(tc_ff);
      widx   = 5'(tf_ff) * 5'd9 + (5'd2 - 5'(tr_ff)) * 5'd3 + 5'(tc_ff);
      weight = pconv_pkg::KERNEL_TABLE[kern_ff][kidx];
   end

   // Dividers, one per color
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         div_mag[ch] = acc_ff[ch][ACC_W-1] ? ACC_W'(-acc_ff[ch]) : ACC_W'(acc_ff[ch]);
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_div
      pconv_div #(
         .DVD_W (ACC_W)
      ) u_div (
         .clock    (clock),
         .reset    (reset),
         .start    (div_start),
         .dividend (div_mag[ch]),
         .divisor  (div_eff),
         .done     (div_done[ch]),
         .quotient (div_quo[ch])
      );
   end

   // Main sequencer
   always_comb begin
      logic signed [VAL_W-1:0] val;
      logic                    last;
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      em_col_in    = em_col_ff;
      em_row_in    = em_row_ff;
      emit_mask_in = emit_mask_ff;
      need_filt_in = need_filt_ff;
      req_in       = req_ff;
      win_in       = win_ff;
      tf_in        = tf_ff;
      tr_in        = tr_ff;
      tc_in        = tc_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      filt_in      = filt_ff;
      div_start    = 1'b0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      val          = '0;
      last         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Shift the window and bring in the new column
            for (int f = 0; f < 3; f++) begin
               for (int wr = 0; wr < 3; wr++) begin
                  win_in[f*9 + wr*3]     = win_ff[f*9 + wr*3 + 1];
                  win_in[f*9 + wr*3 + 1] = win_ff[f*9 + wr*3 + 2];
               end
               win_in[f*9 + 2] = ram_rdata[f*ENT_W + PXW +: PXW];
               win_in[f*9 + 5] = ram_rdata[f*ENT_W +: PXW];
               win_in[f*9 + 8] = in_pix[f];
            end
            // Work out which results this beat causes
            em_row_in       = row_ff;
            em_col_in       = col_ff;
            emit_mask_in[0] = (row_ff == 16'd0) || ((row_ff >= 16'd2) && (col_ff != '0));
            emit_mask_in[1] = (row_ff >= 16'd2) && last_col;
            emit_mask_in[2] = (row_ff >= 16'd2) && last_row;
            need_filt_in    = (row_ff >= 16'd2) && (col_ff >= AW'(2));
            tf_in           = 2'd0;
            tr_in           = 2'd0;
            tc_in           = 2'd0;
            for (int ch = 0; ch < 3; ch++) begin
               acc_in[ch] = '0;
            end
            // Advance the stream position
            if (last_col) begin
               col_in = '0;
               row_in = last_row ? 16'd0 : row_ff + 16'd1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            state_in = ((row_ff >= 16'd2) && (col_ff >= AW'(2))) ? S_MAC : S_EMIT;
         end
         S_MAC: begin
            for (int ch = 0; ch < 3; ch++) begin
               acc_in[ch] = acc_ff[ch] + ACC_W'(weight * $signed({1'b0,
                            win_ff[widx][ch*pconv_pkg::PIX_W +: pconv_pkg::PIX_W]}));
            end
            if (tc_ff == 2'd2) begin
               tc_in = 2'd0;
               if (tr_ff == 2'd2) begin
                  tr_in = 2'd0;
                  tf_in = tf_ff + 2'd1;
                  if (tf_ff == 2'd2) begin
                     state_in = S_DIV;
                  end
               end else begin
                  tr_in = tr_ff + 2'd1;
               end
            end else begin
               tc_in = tc_ff + 2'd1;
            end
            if (state_in == S_DIV) begin
               div_start = 1'b0;
            end
         end
         S_DIV: begin
            if (tf_ff == 2'd3) begin
               // Kick the dividers once on entry
               div_start = 1'b1;
               tf_in     = 2'd0;
               for (int ch = 0; ch < 3; ch++) begin
                  neg_in[ch] = acc_ff[ch][ACC_W-1];
               end
            end else if (&div_done) begin
               for (int ch = 0; ch < 3; ch++) begin
                  val = neg_ff[ch] ? -VAL_W'(div_quo[ch]) : VAL_W'(div_quo[ch]);
                  val = val + VAL_W'($signed(offset_ff));
                  if (val < 0) begin
                     filt_in[ch*pconv_pkg::PIX_W +: pconv_pkg::PIX_W] = 8'd0;
                  end else if (val > VAL_W'(255)) begin
                     filt_in[ch*pconv_pkg::PIX_W +: pconv_pkg::PIX_W] = 8'd255;
                  end else begin
                     filt_in[ch*pconv_pkg::PIX_W +: pconv_pkg::PIX_W] = val[7:0];
                  end
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // Hand out pending results in order, lowest slot first
            if (emit_mask_ff == 3'b000) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (emit_mask_ff[0]) begin
                  last            = (emit_mask_ff[2:1] == 2'b00);
                  emit_mask_in[0] = 1'b0;
                  if (em_row_ff == 16'd0) begin
                     rsp_data_in.out_row = 16'd0;
                     rsp_data_in.out_col = 11'(em_col_ff);
                     {rsp_data_in.out_blue, rsp_data_in.out_green, rsp_data_in.out_red} =
                        win_ff[WIN_CUR];
                  end else begin
                     rsp_data_in.out_row = em_row_ff - 16'd1;
                     rsp_data_in.out_col = 11'(em_col_ff - 1'b1);
                     {rsp_data_in.out_blue, rsp_data_in.out_green, rsp_data_in.out_red} =
                        need_filt_ff ? filt_ff : win_ff[WIN_MID1];
                  end
               end else if (emit_mask_ff[1]) begin
                  last                = !emit_mask_ff[2];
                  emit_mask_in[1]     = 1'b0;
                  rsp_data_in.out_row = em_row_ff - 16'd1;
                  rsp_data_in.out_col = 11'(em_col_ff);
                  {rsp_data_in.out_blue, rsp_data_in.out_green, rsp_data_in.out_red} =
                     win_ff[WIN_MID2];
               end else begin
                  last                = 1'b1;
                  emit_mask_in[2]     = 1'b0;
                  rsp_data_in.out_row = em_row_ff;
                  rsp_data_in.out_col = 11'(em_col_ff);
                  {rsp_data_in.out_blue, rsp_data_in.out_green, rsp_data_in.out_red} =
                     win_ff[WIN_CUR];
               end
               rsp_data_in.last_of_run = last;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kern_ff      <= pconv_pkg::KERNEL_RESET;
         divisor_ff   <= pconv_pkg::DIVISOR_RESET;
         offset_ff    <= pconv_pkg::OFFSET_RESET;
         lw_ff        <= pconv_pkg::WIDTH_RESET;
         fh_ff        <= pconv_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         emit_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
         tf_ff        <= '0;
         tr_ff        <= '0;
         tc_ff        <= '0;
         for (int i = 0; i < pconv_pkg::TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         kern_ff      <= kern_in;
         divisor_ff   <= divisor_in;
         offset_ff    <= offset_in;
         lw_ff        <= lw_in;
         fh_ff        <= fh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         emit_mask_ff <= emit_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         tf_ff        <= tf_in;
         tr_ff        <= tr_in;
         tc_ff        <= tc_in;
         win_ff       <= win_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      em_col_ff    <= em_col_in;
      em_row_ff    <= em_row_in;
      need_filt_ff <= need_filt_in;
      req_ff       <= req_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      filt_ff      <= filt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   `PCONV_ASSERT_NXT(a_accept_reads, clock, reset, accept, state_ff == S_READ)
   `PCONV_ASSERT_IMP(a_idle_no_pending, clock, reset, state_ff == S_IDLE, emit_mask_ff == 3'b000)
   `PCONV_ASSERT_IMP(a_div_done_in_div, clock, reset, &div_done, state_ff == S_DIV)

endmodule

`default_nettype wire

FILE: dv/pconv_filter_checker.sv
// Result checker for the 3x3x3 convolution filter: watches all ports, predicts and compares
`timescale 1ns / 1ps
`default_nettype none

module pconv_filter_checker
   import pconv_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire req_payload_type       req_data,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire rsp_payload_type       rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DAT_W-1:0]  csr_wdata,
   output int                         error_count,
   output int                         pixels_pending,
   output int                         pixels_checked
);

   // Shadow copy of the registers
   logic [1:0]  kernel_sel;
   logic [15:0] divisor_reg;
   logic [15:0] offset_reg;
   logic [11:0] width_reg;
   logic [15:0] height_reg;

   // Line stores: bits 23:0 the row just above, 47:24 the row above that
   logic [47:0] line_mem [0:2][0:MAX_LINE_WIDTH-1];
   // [frame][row: 0 two above, 1 one above, 2 current][col: 0 oldest .. 2 newest]
   logic [23:0] win_px [0:2][0:2][0:2];
   int unsigned row_pos;
   int unsigned col_pos;

   rsp_payload_type expected_pixels[$];

   assign pixels_pending = expected_pixels.size();

   // Weighted sum of one color over the window, divided, offset and clamped
   function automatic logic [7:0] filter_channel(input int ch);
      int sum;
      int dv;
      int v;
      sum = 0;
      dv  = (divisor_reg == 16'd0) ? 1 : int'(divisor_reg);
      for (int f = 0; f < 3; f++)
         for (int wr = 0; wr < 3; wr++)
            for (int wc = 0; wc < 3; wc++)
               sum += int'(KERNEL_TABLE[kernel_sel][f*9 + (2-wr)*3 + wc])
                      * int'(win_px[f][wr][wc][8*ch +: 8]);
      v = sum / dv + int'($signed(offset_reg));
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic void push_pixel(input int unsigned r, input int unsigned c,
                                      input logic [23:0] px);
      rsp_payload_type e;
      e.out_row     = r[15:0];
      e.out_col     = c[10:0];
      e.out_red     = px[7:0];
      e.out_green   = px[15:8];
      e.out_blue    = px[23:16];
      e.last_of_run = 1'b0;
      expected_pixels.push_back(e);
   endfunction

   // Advance the stream position by one beat and queue the pixels it releases
   task automatic predict_pixel_step(input req_payload_type d);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned idx;
      int          n0;
      bit          last_col;
      bit          last_row;
      logic [23:0] px [0:2];
      logic [47:0] e;
      logic [23:0] filt;
      w = (width_reg < 12'd3) ? 3 : int'(width_reg);
      if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
      h = (height_reg < 16'd3) ? 3 : int'(height_reg);
      r = row_pos;
      c = col_pos;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      idx = c % MAX_LINE_WIDTH;
      n0  = expected_pixels.size();
      px[0] = {d.prev_blue, d.prev_green, d.prev_red};
      px[1] = {d.cur_blue,  d.cur_green,  d.cur_red};
      px[2] = {d.next_blue, d.next_green, d.next_red};

      // Shift the window left and pull in the new column
      for (int f = 0; f < 3; f++) begin
         e = line_mem[f][idx];
         for (int wr = 0; wr < 3; wr++) begin
            win_px[f][wr][0] = win_px[f][wr][1];
            win_px[f][wr][1] = win_px[f][wr][2];
         end
         win_px[f][0][2] = e[47:24];
         win_px[f][1][2] = e[23:0];
         win_px[f][2][2] = px[f];
         line_mem[f][idx] = {e[23:0], px[f]};
      end

      if (r == 0) begin
         push_pixel(0, c, win_px[1][2][2]);
      end else if (r >= 2) begin
         if (c >= 1) begin
            if (c == 1) begin
               push_pixel(r - 1, 0, win_px[1][1][1]);
            end else begin
               filt = {filter_channel(2), filter_channel(1), filter_channel(0)};
               push_pixel(r - 1, c - 1, filt);
            end
         end
         if (last_col) push_pixel(r - 1, c, win_px[1][1][2]);
         if (last_row) push_pixel(r, c, win_px[1][2][2]);
      end
      if (expected_pixels.size() > n0)
         expected_pixels[expected_pixels.size()-1].last_of_run = 1'b1;

      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type e;
      if (reset) begin
         kernel_sel  <= KERNEL_RESET;
         divisor_reg <= DIVISOR_RESET;
         offset_reg  <= OFFSET_RESET;
         width_reg   <= WIDTH_RESET;
         height_reg  <= HEIGHT_RESET;
         row_pos = 0;
         col_pos = 0;
         for (int f = 0; f < 3; f++)
            for (int wr = 0; wr < 3; wr++)
               for (int wc = 0; wc < 3; wc++)
                  win_px[f][wr][wc] = '0;
         expected_pixels.delete();
         error_count    <= 0;
         pixels_checked <= 0;
      end else begin
         // Track register writes
         if (csr_we) begin
            case (csr_index)
               CSR_KERNEL_SELECT: kernel_sel  <= csr_wdata[1:0];
               CSR_DIVISOR:       divisor_reg <= csr_wdata;
               CSR_OFFSET:        offset_reg  <= csr_wdata;
               CSR_LINE_WIDTH:    width_reg   <= csr_wdata[11:0];
               CSR_FRAME_HEIGHT:  height_reg  <= csr_wdata;
               default: ;
            endcase
         end
         // Compare the result beat before predicting, so a same-cycle beat is not matched
         if (rsp_valid && rsp_ready) begin
            pixels_checked <= pixels_checked + 1;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result beat %p", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               e = expected_pixels.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_pixel_step(req_data);
      end
   end

endmodule

`default_nettype wire

FILE: dv/tb_pixel_3x3x3_convolution_filter.sv
// Testbench top for the 3x3x3 convolution filter: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_pixel_3x3x3_convolution_filter;
   import pconv_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 80;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_KERNEL_SELECT;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   int  error_count;
   int  pixels_pending;
   int  pixels_checked;
   int  pixels_sent = 0;
   int  settings_run = 0;
   int  cycles = 0;
   bit  no_gaps = 1'b0;

   pixel_3x3x3_convolution_filter i_dut (.*);

   pconv_filter_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: stall at random, with a chance of 6 in 100, unless gaps are off
   always @(negedge clock) rsp_ready <= no_gaps || ($urandom_range(99) >= 6);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Wait until every queued result has arrived and in-flight beats have drained
   task automatic drain_results;
      req_valid <= 1'b0;
      @(negedge clock);
      while (pixels_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Hold valid until the beat is taken; insert random gaps first
   task automatic send_pixel(input req_payload_type p);
      while (!no_gaps && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
   endtask

   // Pixel styles: 0 random, 1 all ones, 2 all zeros, 3 checkerboard of extremes
   function automatic req_payload_type make_pixel(input int style, input int n);
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      case (style)
         1: bits = '1;
         2: bits = '0;
         3: bits = (n % 2) ? '1 : '0;
         default: ;
      endcase
      return bits[71:0];
   endfunction

   task automatic apply_setting(input int k, input int unsigned dv, input int unsigned off,
                                input int unsigned w, input int unsigned h);
      write_reg(CSR_KERNEL_SELECT, k);
      write_reg(CSR_DIVISOR, dv);
      write_reg(CSR_OFFSET, off);
      write_reg(CSR_LINE_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      settings_run++;
   endtask

   // Stream a number of pixel beats, then drain so the next setting starts idle
   task automatic run_frames(input int count, input int style);
      for (int i = 0; i < count; i++) send_pixel(make_pixel(style, i));
      drain_results();
   endtask

   function automatic int unsigned pick_divisor();
      case ($urandom_range(5))
         0: return 84;
         1: return 1;
         2: return 53;
         3: return 69;
         4: return $urandom_range(65535);
         default: return $urandom_range(200);
      endcase
   endfunction

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned off;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: saturated and zero frames, and a checkerboard on the high-pass kernel
      apply_setting(0, 84, 0, 3, 3);
      run_frames(9, 1);
      apply_setting(1, 1, 0, 3, 3);
      run_frames(9, 3);
      apply_setting(2, 1, 16'h8000, 3, 3);
      run_frames(9, 1);
      // Out-of-range width and height clamp to 3, zero divisor acts as 1
      apply_setting(3, 0, 16'h7FFF, 0, 1);
      run_frames(9, 2);

      // Over-range width clamps to the line store depth; narrow the line mid-row
      apply_setting(3, 65535, 16'h7FFF, 4095, 3);
      run_frames(2, 0);
      write_reg(CSR_LINE_WIDTH, 3);
      run_frames(7, 0);

      // Tall frame cut short: the row counter has passed the new end and wraps
      apply_setting(1, 53, 16'hFFFB, 3, 65535);
      run_frames(15, 0);
      write_reg(CSR_FRAME_HEIGHT, 3);
      run_frames(3, 0);

      // Random settings, one small frame each; the first stretch runs with no idling
      no_gaps = 1'b1;
      while (pixels_sent < 350) begin
         if (pixels_sent >= 200) no_gaps = 1'b0;
         w = $urandom_range(3, 8);
         h = $urandom_range(3, 6);
         case ($urandom_range(3))
            0: off = 16'h8000;
            1: off = 16'h7FFF;
            default: off = $urandom_range(40) - 20;
         endcase
         apply_setting($urandom_range(3), pick_divisor(), off, w, h);
         run_frames(w * h, ($urandom_range(9) == 0) ? 3 : 0);
      end
      no_gaps = 1'b0;

      $display("Covered %0d pixel beats and %0d result beats over %0d register settings",
               pixels_sent, pixels_checked, settings_run);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pconv_pkg.sv
hw/rtl/pconv_ram.sv
hw/rtl/pconv_div.sv
hw/rtl/pixel_3x3x3_convolution_filter.sv
dv/pconv_filter_checker.sv
dv/tb_pixel_3x3x3_convolution_filter.sv
